// ===== rtl/rlid_pkg.sv =====
`timescale 1ns / 1ps
// Package for the run-length image decoder.
// Holds the phase and control types, status and action codes, and header constants.
package rlid_pkg;

	localparam int MAX_RUNS = 1024;
	localparam int RUN_AW = $clog2(MAX_RUNS);
	localparam int RUN_CW = $clog2(MAX_RUNS + 1);

	localparam logic [1:0] ACT_BYTE = 2'd0;
	localparam logic [1:0] ACT_EOS = 2'd1;
	localparam logic [1:0] ACT_PULL = 2'd2;

	localparam logic [2:0] ST_TAKEN = 3'd0;
	localparam logic [2:0] ST_PIXEL = 3'd1;
	localparam logic [2:0] ST_DONE = 3'd2;
	localparam logic [2:0] ST_MAGIC = 3'd3;
	localparam logic [2:0] ST_OVER = 3'd4;
	localparam logic [2:0] ST_NOTREADY = 3'd5;

	localparam logic [7:0] MAGIC_0 = 8'h50;
	localparam logic [7:0] MAGIC_1 = 8'h5A;

	localparam logic [4:0] HDR_POS_MAGIC0 = 5'd0;
	localparam logic [4:0] HDR_POS_MAGIC1 = 5'd1;
	localparam logic [4:0] HDR_POS_WIDTH_HI = 5'd10;
	localparam logic [4:0] HDR_POS_WIDTH_LO = 5'd11;
	localparam logic [4:0] HDR_POS_HEIGHT_HI = 5'd12;
	localparam logic [4:0] HDR_POS_HEIGHT_LO = 5'd13;
	localparam logic [4:0] HDR_POS_FLAGS = 5'd18;
	localparam logic [4:0] HDR_POS_LAST = 5'd21;
	localparam int GRAY_BIT = 1;

	localparam logic [4:0] WORD_POS_LAST = 5'd3;
	localparam logic [1:0] COMP_POS_LAST = 2'd2;

	typedef enum logic [7:0] {
		PH_HEADER    = 8'b0000_0001,
		PH_DESC      = 8'b0000_0010,
		PH_COUNT     = 8'b0000_0100,
		PH_LENGTHS   = 8'b0000_1000,
		PH_COLORS    = 8'b0001_0000,
		PH_EMIT      = 8'b0010_0000,
		PH_ERR_MAGIC = 8'b0100_0000,
		PH_ERR_OVER  = 8'b1000_0000
	} phase_t;

	typedef enum logic [2:0] {
		CTL_IDLE = 3'b001,
		CTL_RD   = 3'b010,
		CTL_CHK  = 3'b100
	} ctl_t;

endpackage

// ===== rtl/run_length_image_decoder.sv =====
`timescale 1ns / 1ps
// Run-length image decoder: a byte-wise header and run parser with run length and color memories.
// Depends on rlid_pkg.
// A word that needs no run scan gives its registered result in the cycle after it is taken.
// End of stream, and a pull that finishes a run, scan the length memory for the next
// nonzero run, reading and then checking each run examined; the result follows the
// word once a nonzero run is found, or once the scan runs past the last run.
// Throughput: one word per cycle while no scan runs and the output is not stalled.
// Reset: asynchronous, active low; all control state clears, the memories are not cleared.
module run_length_image_decoder
	import rlid_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        last_pixel,
	output logic [15:0] image_width,
	output logic [15:0] image_height,
	output logic        is_grayscale
);

	phase_t phase_q;
	ctl_t ctl_q;
	logic [4:0] byte_pos_q;
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic gray_q;
	logic [31:0] word_q;
	logic [RUN_CW-1:0] runs_total_q;
	logic [RUN_CW-1:0] run_index_q;
	logic [1:0] comp_q;
	logic [31:0] run_offset_q;
	logic [31:0] cur_len_q;
	logic [23:0] cur_color_q;
	logic pull_q;
	logic out_valid_q;
	logic [2:0] status_q;
	logic [7:0] red_q;
	logic [7:0] green_q;
	logic [7:0] blue_q;
	logic last_q;

	logic [31:0] length_mem [MAX_RUNS];
	logic [23:0] color_mem [MAX_RUNS];
	logic [31:0] len_rd_q;
	logic [23:0] col_rd_q;

	logic in_acc;
	logic byte_acc;
	logic [31:0] word_next;
	logic [32:0] off_inc;
	logic [RUN_CW-1:0] idx_inc;
	logic len_we;
	logic col_we;
	logic [23:0] col_wdata;

	assign in_stall = (ctl_q != CTL_IDLE) || (out_valid_q && out_stall);
	assign in_acc = in_valid && !in_stall;
	assign byte_acc = in_acc && (action == ACT_BYTE)
		&& (phase_q != PH_ERR_MAGIC) && (phase_q != PH_ERR_OVER);
	assign word_next = {word_q[23:0], data_byte};
	assign off_inc = {1'b0, run_offset_q} + 33'd1;
	assign idx_inc = run_index_q + {{(RUN_CW-1){1'b0}}, 1'b1};

	assign len_we = byte_acc && (phase_q == PH_LENGTHS) && (byte_pos_q == WORD_POS_LAST);
	assign col_we = byte_acc && (phase_q == PH_COLORS) && (run_index_q < runs_total_q)
		&& (gray_q || (comp_q == COMP_POS_LAST));
	assign col_wdata = gray_q ? {data_byte, data_byte, data_byte} : {word_q[15:0], data_byte};

	always_ff @(posedge clk) begin
		if (len_we) begin
			length_mem[run_index_q[RUN_AW-1:0]] <= word_next;
		end
		if (col_we) begin
			color_mem[run_index_q[RUN_AW-1:0]] <= col_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_q == CTL_RD) begin
			len_rd_q <= length_mem[run_index_q[RUN_AW-1:0]];
			col_rd_q <= color_mem[run_index_q[RUN_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			ctl_q <= CTL_IDLE;
			byte_pos_q <= '0;
			width_q <= '0;
			height_q <= '0;
			gray_q <= 1'b0;
			word_q <= '0;
			runs_total_q <= '0;
			run_index_q <= '0;
			comp_q <= '0;
			run_offset_q <= '0;
			cur_len_q <= '0;
			cur_color_q <= '0;
			pull_q <= 1'b0;
			out_valid_q <= 1'b0;
			status_q <= ST_TAKEN;
			red_q <= '0;
			green_q <= '0;
			blue_q <= '0;
			last_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (ctl_q)
				CTL_IDLE: begin
					if (in_acc) begin
						out_valid_q <= 1'b1;
						red_q <= '0;
						green_q <= '0;
						blue_q <= '0;
						last_q <= 1'b0;
						status_q <= ST_NOTREADY;
						if (phase_q == PH_ERR_MAGIC) begin
							status_q <= ST_MAGIC;
						end else if (phase_q == PH_ERR_OVER) begin
							status_q <= ST_OVER;
						end else if (action == ACT_BYTE) begin
							status_q <= ST_TAKEN;
							case (phase_q)
								PH_HEADER: begin
									if (byte_pos_q == HDR_POS_MAGIC0) begin
										word_q <= {31'd0, data_byte == MAGIC_0};
									end
									if (byte_pos_q == HDR_POS_WIDTH_HI
										|| byte_pos_q == HDR_POS_WIDTH_LO) begin
										width_q <= {width_q[7:0], data_byte};
									end
									if (byte_pos_q == HDR_POS_HEIGHT_HI
										|| byte_pos_q == HDR_POS_HEIGHT_LO) begin
										height_q <= {height_q[7:0], data_byte};
									end
									if (byte_pos_q == HDR_POS_FLAGS) begin
										gray_q <= data_byte[GRAY_BIT];
									end
									if (byte_pos_q == HDR_POS_MAGIC1
										&& (!word_q[0] || data_byte != MAGIC_1)) begin
										phase_q <= PH_ERR_MAGIC;
										status_q <= ST_MAGIC;
									end else if (byte_pos_q >= HDR_POS_LAST) begin
										phase_q <= PH_DESC;
										byte_pos_q <= '0;
									end else begin
										byte_pos_q <= byte_pos_q + 5'd1;
									end
								end
								PH_DESC: begin
									if (data_byte == 8'd0) begin
										phase_q <= PH_COUNT;
										byte_pos_q <= '0;
										word_q <= '0;
									end
								end
								PH_COUNT: begin
									if (byte_pos_q == WORD_POS_LAST) begin
										byte_pos_q <= '0;
										if (word_next > 32'(MAX_RUNS)) begin
											phase_q <= PH_ERR_OVER;
											status_q <= ST_OVER;
										end else begin
											runs_total_q <= word_next[RUN_CW-1:0];
											run_index_q <= '0;
											word_q <= '0;
											comp_q <= '0;
											phase_q <= (word_next == 32'd0) ? PH_COLORS : PH_LENGTHS;
										end
									end else begin
										word_q <= word_next;
										byte_pos_q <= byte_pos_q + 5'd1;
									end
								end
								PH_LENGTHS: begin
									if (byte_pos_q == WORD_POS_LAST) begin
										byte_pos_q <= '0;
										word_q <= '0;
										if (idx_inc >= runs_total_q) begin
											run_index_q <= '0;
											comp_q <= '0;
											phase_q <= PH_COLORS;
										end else begin
											run_index_q <= idx_inc;
										end
									end else begin
										word_q <= word_next;
										byte_pos_q <= byte_pos_q + 5'd1;
									end
								end
								PH_COLORS: begin
									if (run_index_q >= runs_total_q) begin
										phase_q <= PH_ERR_OVER;
										status_q <= ST_OVER;
									end else if (gray_q) begin
										run_index_q <= idx_inc;
									end else if (comp_q == COMP_POS_LAST) begin
										word_q <= '0;
										comp_q <= '0;
										run_index_q <= idx_inc;
									end else begin
										word_q <= {8'd0, word_next[23:0]};
										comp_q <= comp_q + 2'd1;
									end
								end
								default: begin
									status_q <= ST_NOTREADY;
								end
							endcase
						end else if (action == ACT_EOS) begin
							status_q <= ST_TAKEN;
							if (phase_q == PH_HEADER || phase_q == PH_DESC
								|| phase_q == PH_COUNT || phase_q == PH_LENGTHS
								|| phase_q == PH_COLORS) begin
								if (phase_q == PH_LENGTHS) begin
									runs_total_q <= run_index_q;
								end else if (phase_q != PH_COLORS) begin
									runs_total_q <= '0;
								end
								phase_q <= PH_EMIT;
								run_index_q <= '0;
								run_offset_q <= '0;
								pull_q <= 1'b0;
								out_valid_q <= 1'b0;
								ctl_q <= CTL_RD;
							end
						end else if (action == ACT_PULL) begin
							if (phase_q != PH_EMIT) begin
								status_q <= ST_NOTREADY;
							end else if (run_index_q >= runs_total_q) begin
								status_q <= ST_DONE;
							end else begin
								status_q <= ST_PIXEL;
								red_q <= cur_color_q[23:16];
								green_q <= cur_color_q[15:8];
								blue_q <= cur_color_q[7:0];
								if (off_inc >= {1'b0, cur_len_q}) begin
									run_index_q <= idx_inc;
									run_offset_q <= '0;
									pull_q <= 1'b1;
									out_valid_q <= 1'b0;
									ctl_q <= CTL_RD;
								end else begin
									run_offset_q <= off_inc[31:0];
								end
							end
						end
					end
				end
				CTL_RD: begin
					if (run_index_q >= runs_total_q) begin
						out_valid_q <= 1'b1;
						last_q <= pull_q;
						ctl_q <= CTL_IDLE;
					end else begin
						ctl_q <= CTL_CHK;
					end
				end
				CTL_CHK: begin
					if (len_rd_q == 32'd0) begin
						run_index_q <= idx_inc;
						ctl_q <= CTL_RD;
					end else begin
						cur_len_q <= len_rd_q;
						cur_color_q <= col_rd_q;
						out_valid_q <= 1'b1;
						last_q <= 1'b0;
						ctl_q <= CTL_IDLE;
					end
				end
				default: begin
					ctl_q <= CTL_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign red = red_q;
	assign green = green_q;
	assign blue = blue_q;
	assign last_pixel = last_q;
	assign image_width = width_q;
	assign image_height = height_q;
	assign is_grayscale = gray_q;

	// A read issued for a run inside the table is always checked on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_q == CTL_RD && run_index_q < runs_total_q) |=> (ctl_q == CTL_CHK))
		else $error("scan read not followed by check");

	// While pixels are handed out, the run pointer never passes the run count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_EMIT && ctl_q == CTL_IDLE) |-> (run_index_q <= runs_total_q))
		else $error("run index beyond run count");

	assert property (@(posedge clk) disable iff (!arst_n)
		runs_total_q <= RUN_CW'(MAX_RUNS))
		else $error("run count above table depth");

	// A pixel word can only come from the emit phase, and the output is never reloaded
	// during a scan.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_PIXEL) |-> (phase_q == PH_EMIT))
		else $error("pixel word outside emit phase");

	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_q != CTL_IDLE) |-> !out_valid_q)
		else $error("result word valid during run scan");

endmodule
